@@ hw/rtl/leirs_pkg.sv @@
// shared types and constants for the list engine
package leirs_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int AW         = $clog2(CAPACITY);
   localparam int CW         = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      CMD_APPEND     = 4'd0,
      CMD_INSERT     = 4'd1,
      CMD_REMOVE_VAL = 4'd2,
      CMD_REMOVE_AT  = 4'd3,
      CMD_FIND       = 4'd4,
      CMD_REVERSE    = 4'd5,
      CMD_SORT_UP    = 4'd6,
      CMD_SORT_DOWN  = 4'd7,
      CMD_READ       = 4'd8,
      CMD_WRITE      = 4'd9,
      CMD_CLEAR      = 4'd10
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_RANGE     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [3:0]         command;
      logic signed [31:0] value;
      logic [6:0]         index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic [5:0]         position;
      logic signed [31:0] read_data;
      logic [6:0]         count;
   } rsp_type;

   typedef enum logic [3:0] {
      FS_IDLE,
      FS_SCAN_RD,
      FS_SCAN_CMP,
      FS_SHIFT_RD,
      FS_SHIFT_WR,
      FS_PAIR_RD_A,
      FS_PAIR_RD_B,
      FS_PAIR_WR_A,
      FS_PAIR_WR_B,
      FS_READ_WAIT,
      FS_RESPOND
   } fsm_type;

   // memory request from the sequencer
   typedef struct packed {
      logic                  we;
      logic [AW-1:0]         addr;
      logic [DATA_WIDTH-1:0] wdata;
   } mem_req_type;

endpackage

@@ hw/rtl/list_engine_insert_remove_sort.sv @@
// list engine: sequencer over a single-port element memory
// append, write, clear and range errors go straight to the response state; scans, shifts
// and reverse step through the elements; sort is up to n-1 bubble passes, each pair read
// and written back only on a swap; a pass with no swap ends the sort early
// one request at a time; every element access goes through the single memory port
// reset: synchronous, clears the count and returns to idle; memory contents are left as is
module list_engine_insert_remove_sort (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  leirs_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output leirs_pkg::rsp_type  rsp_data
);
   import leirs_pkg::*;

   fsm_type state_ff, state_in;
   logic [CW-1:0] len_ff, len_in;
   logic [3:0] cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] i_ff, i_in;     // walking pointer
   logic [CW-1:0] j_ff, j_in;     // second pointer / pass limit
   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic swapped_ff, swapped_in;
   logic shift_up_ff, shift_up_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   mem_req_type mreq;
   logic [DATA_WIDTH-1:0] rdata;
   logic desc, do_swap;

   leirs_ram u_ram (.clock(clock), .mem_req(mreq), .rdata(rdata));

   assign desc = (cmd_ff == CMD_SORT_DOWN);
   assign do_swap = desc ? ($signed(a_ff) < $signed(rdata)) : ($signed(a_ff) > $signed(rdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FS_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in; val_ff <= val_in; idx_ff <= idx_in;
      i_ff <= i_in; j_ff <= j_in; a_ff <= a_in;
      swapped_ff <= swapped_in; shift_up_ff <= shift_up_in; rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff; len_in = len_ff; cmd_in = cmd_ff; val_in = val_ff;
      idx_in = idx_ff; i_in = i_ff; j_in = j_ff; a_in = a_ff;
      swapped_in = swapped_ff; shift_up_in = shift_up_ff;
      rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff;
      mreq = '{we: 1'b0, addr: i_ff[AW-1:0], wdata: '0};
      req_ready = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         FS_IDLE: begin
            // the response register doubles as scratch, so wait until it drains
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd_in = req_data.command;
               val_in = DATA_WIDTH'(req_data.value);
               idx_in = CW'(req_data.index);
               rsp_in = '0;
               state_in = FS_RESPOND;
               case (req_data.command)
                  CMD_APPEND: begin
                     if (len_ff >= CW'(CAPACITY)) rsp_in.status = ST_FULL;
                     else begin
                        mreq = '{we: 1'b1, addr: len_ff[AW-1:0],
                                 wdata: DATA_WIDTH'(req_data.value)};
                        len_in = len_ff + 1'b1;
                     end
                  end
                  CMD_INSERT: begin
                     if (CW'(req_data.index) > len_ff) rsp_in.status = ST_RANGE;
                     else if (len_ff >= CW'(CAPACITY)) rsp_in.status = ST_FULL;
                     else begin
                        // move entries up from the top down to index
                        i_in = len_ff; shift_up_in = 1'b1;
                        state_in = FS_SHIFT_RD;
                     end
                  end
                  CMD_REMOVE_VAL, CMD_FIND: begin
                     i_in = '0; state_in = FS_SCAN_RD;
                  end
                  CMD_REMOVE_AT: begin
                     if (CW'(req_data.index) >= len_ff) rsp_in.status = ST_RANGE;
                     else begin
                        i_in = CW'(req_data.index); shift_up_in = 1'b0;
                        state_in = FS_SHIFT_RD;
                     end
                  end
                  CMD_REVERSE: begin
                     if (len_ff > 1) begin
                        i_in = '0; j_in = len_ff - 1'b1; state_in = FS_PAIR_RD_A;
                     end
                  end
                  CMD_SORT_UP, CMD_SORT_DOWN: begin
                     if (len_ff > 1) begin
                        i_in = '0; j_in = len_ff - 1'b1; swapped_in = 1'b0;
                        state_in = FS_PAIR_RD_A;
                     end
                  end
                  CMD_READ: begin
                     if (CW'(req_data.index) >= len_ff) rsp_in.status = ST_RANGE;
                     else begin
                        mreq.addr = req_data.index[AW-1:0];
                        state_in = FS_READ_WAIT;
                     end
                  end
                  CMD_WRITE: begin
                     if (CW'(req_data.index) >= len_ff) rsp_in.status = ST_RANGE;
                     else mreq = '{we: 1'b1, addr: req_data.index[AW-1:0],
                                   wdata: DATA_WIDTH'(req_data.value)};
                  end
                  CMD_CLEAR: len_in = '0;
                  default: ;
               endcase
            end
         end
         FS_READ_WAIT: begin
            rsp_in.read_data = rdata;
            state_in = FS_RESPOND;
         end
         FS_SCAN_RD: begin
            if (i_ff >= len_ff) begin
               rsp_in.status = ST_NOT_FOUND; state_in = FS_RESPOND;
            end else begin
               mreq.addr = i_ff[AW-1:0]; state_in = FS_SCAN_CMP;
            end
         end
         FS_SCAN_CMP: begin
            if (rdata == val_ff) begin
               if (cmd_ff == CMD_FIND) begin
                  rsp_in.found = 1'b1; rsp_in.position = i_ff[5:0];
                  state_in = FS_RESPOND;
               end else begin
                  shift_up_in = 1'b0; state_in = FS_SHIFT_RD;
               end
            end else begin
               i_in = i_ff + 1'b1; state_in = FS_SCAN_RD;
            end
         end
         FS_SHIFT_RD: begin
            if (shift_up_ff) begin
               if (i_ff == idx_ff) begin
                  mreq = '{we: 1'b1, addr: i_ff[AW-1:0], wdata: val_ff};
                  len_in = len_ff + 1'b1; state_in = FS_RESPOND;
               end else begin
                  mreq.addr = AW'(i_ff - 1'b1); state_in = FS_SHIFT_WR;
               end
            end else begin
               if (i_ff + 1'b1 >= len_ff) begin
                  // vacated top slot goes to zero
                  mreq = '{we: 1'b1, addr: i_ff[AW-1:0], wdata: '0};
                  len_in = len_ff - 1'b1; state_in = FS_RESPOND;
               end else begin
                  mreq.addr = AW'(i_ff + 1'b1); state_in = FS_SHIFT_WR;
               end
            end
         end
         FS_SHIFT_WR: begin
            mreq = '{we: 1'b1, addr: i_ff[AW-1:0], wdata: rdata};
            i_in = shift_up_ff ? i_ff - 1'b1 : i_ff + 1'b1;
            state_in = FS_SHIFT_RD;
         end
         FS_PAIR_RD_A: begin
            mreq.addr = i_ff[AW-1:0]; state_in = FS_PAIR_RD_B;
         end
         FS_PAIR_RD_B: begin
            a_in = rdata;
            mreq.addr = (cmd_ff == CMD_REVERSE) ? j_ff[AW-1:0] : AW'(i_ff + 1'b1);
            state_in = FS_PAIR_WR_A;
         end
         FS_PAIR_WR_A: begin
            // rdata holds the second element; a_ff the first
            if (cmd_ff == CMD_REVERSE || do_swap) begin
               mreq = '{we: 1'b1, addr: i_ff[AW-1:0], wdata: rdata};
               swapped_in = swapped_ff | (cmd_ff != CMD_REVERSE);
               state_in = FS_PAIR_WR_B;
            end else begin
               i_in = i_ff + 1'b1;
               if (i_ff + 1'b1 >= j_ff) begin
                  j_in = j_ff - 1'b1;
                  i_in = '0; swapped_in = 1'b0;
                  state_in = (j_ff <= 1 || !swapped_ff) ? FS_RESPOND : FS_PAIR_RD_A;
               end else state_in = FS_PAIR_RD_A;
            end
         end
         FS_PAIR_WR_B: begin
            if (cmd_ff == CMD_REVERSE) begin
               mreq = '{we: 1'b1, addr: j_ff[AW-1:0], wdata: a_ff};
               i_in = i_ff + 1'b1; j_in = j_ff - 1'b1;
               state_in = (i_ff + 2'd2 >= j_ff) ? FS_RESPOND : FS_PAIR_RD_A;
            end else begin
               mreq = '{we: 1'b1, addr: AW'(i_ff + 1'b1), wdata: a_ff};
               i_in = i_ff + 1'b1;
               if (i_ff + 1'b1 >= j_ff) begin
                  j_in = j_ff - 1'b1; i_in = '0; swapped_in = 1'b0;
                  state_in = (j_ff <= 1) ? FS_RESPOND : FS_PAIR_RD_A;
               end else state_in = FS_PAIR_RD_A;
            end
         end
         FS_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.count = len_ff;
               rsp_valid_in = 1'b1;
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CW'(CAPACITY)) else $error("count above capacity");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == FS_IDLE) else $error("ready outside idle");
   a_rsp_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.status == ST_DONE)
      else $error("found with error status");
endmodule

@@ hw/rtl/leirs_ram.sv @@
// single-port element memory with registered read
module leirs_ram (
   input  logic                      clock,
   input  leirs_pkg::mem_req_type    mem_req,
   output logic [leirs_pkg::DATA_WIDTH-1:0] rdata
);
   import leirs_pkg::*;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      rdata_ff <= mem[mem_req.addr];
   end

   assign rdata = rdata_ff;
endmodule

@@ dv/list_engine_insert_remove_sort_tb.sv @@
// testbench for the list engine: random and directed requests checked against a list model
module list_engine_insert_remove_sort_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import leirs_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   list_engine_insert_remove_sort dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // list shadow
   logic signed [31:0] shadow_list [CAPACITY];
   int                 shadow_len;
   // stimulus-side shadow of the length, used to aim indexes mostly inside written entries
   int                 plan_len;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      mismatch_count = 0;
   int      rsp_count = 0;
   int      req_count = 0;
   int      cmd_hits [16];
   bit      drain_req = 1'b0;
   bit      stim_done = 1'b0;

   function automatic int first_index(logic signed [31:0] v);
      for (int i = 0; i < shadow_len; i++)
         if (shadow_list[i] == v) return i;
      return -1;
   endfunction

   function automatic void drop_entry(int pos);
      for (int i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
      shadow_list[shadow_len - 1] = '0;
      shadow_len--;
   endfunction

   function automatic void sort_shadow(bit descending);
      logic signed [31:0] t;
      for (int i = 0; i + 1 < shadow_len; i++)
         for (int j = 0; j + 1 < shadow_len - i; j++)
            if (descending ? (shadow_list[j] < shadow_list[j + 1])
                           : (shadow_list[j] > shadow_list[j + 1])) begin
               t = shadow_list[j];
               shadow_list[j] = shadow_list[j + 1];
               shadow_list[j + 1] = t;
            end
   endfunction

   function automatic rsp_type apply_command(req_type r);
      rsp_type            o;
      int                 p;
      int                 idx;
      logic signed [31:0] t;
      o = '0;
      idx = r.index;
      case (r.command)
         CMD_APPEND: begin
            if (shadow_len >= CAPACITY) o.status = ST_FULL;
            else begin
               shadow_list[shadow_len] = r.value;
               shadow_len++;
            end
         end
         CMD_INSERT: begin
            if (idx > shadow_len) o.status = ST_RANGE;
            else if (shadow_len >= CAPACITY) o.status = ST_FULL;
            else begin
               for (int i = shadow_len; i > idx; i--) shadow_list[i] = shadow_list[i - 1];
               shadow_list[idx] = r.value;
               shadow_len++;
            end
         end
         CMD_REMOVE_VAL: begin
            p = first_index(r.value);
            if (p < 0) o.status = ST_NOT_FOUND;
            else drop_entry(p);
         end
         CMD_REMOVE_AT: begin
            if (idx >= shadow_len) o.status = ST_RANGE;
            else drop_entry(idx);
         end
         CMD_FIND: begin
            p = first_index(r.value);
            if (p < 0) o.status = ST_NOT_FOUND;
            else begin
               o.found = 1'b1;
               o.position = p[5:0];
            end
         end
         CMD_REVERSE: begin
            for (int i = 0; i < shadow_len / 2; i++) begin
               t = shadow_list[i];
               shadow_list[i] = shadow_list[shadow_len - 1 - i];
               shadow_list[shadow_len - 1 - i] = t;
            end
         end
         CMD_SORT_UP:   sort_shadow(1'b0);
         CMD_SORT_DOWN: sort_shadow(1'b1);
         CMD_READ: begin
            if (idx >= shadow_len) o.status = ST_RANGE;
            else o.read_data = shadow_list[idx];
         end
         CMD_WRITE: begin
            if (idx >= shadow_len) o.status = ST_RANGE;
            else shadow_list[idx] = r.value;
         end
         CMD_CLEAR: begin
            for (int i = 0; i < CAPACITY; i++) shadow_list[i] = '0;
            shadow_len = 0;
         end
         default: ;
      endcase
      o.count = shadow_len[6:0];
      return o;
   endfunction

   // track the length at planning time so the stimulus can aim at valid indexes
   function automatic void plan_request(logic [3:0] cmd, logic signed [31:0] v,
                                        logic [6:0] idx);
      req_type r;
      r.command = cmd;
      r.value = v;
      r.index = idx;
      pending_reqs.push_back(r);
      case (cmd)
         CMD_APPEND: if (plan_len < CAPACITY) plan_len++;
         CMD_INSERT: if (idx <= plan_len && plan_len < CAPACITY) plan_len++;
         CMD_REMOVE_AT: if (idx < plan_len) plan_len--;
         CMD_CLEAR: plan_len = 0;
         default: ;
      endcase
   endfunction

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 4))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $signed(32'($urandom_range(0, 7)) - 32'd3);
         default: return $signed($urandom);
      endcase
   endfunction

   // random index: mostly in range, sometimes at or past the end
   function automatic logic [6:0] random_index();
      if (plan_len > 0 && $urandom_range(0, 3) != 0) return 7'($urandom_range(0, plan_len - 1));
      if ($urandom_range(0, 1)) return 7'(plan_len);
      return 7'($urandom_range(0, 127));
   endfunction

   // driver
   int  send_gap = 0;
   bit  quiet_send = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= $urandom_range(0, 13);
      end else if (req_valid && !req_ready) begin
         // hold
      end else begin
         if (req_valid) begin
            expected_rsps.push_back(apply_command(req_data));
            cmd_hits[req_data.command]++;
            req_count++;
            void'(pending_reqs.pop_front());
         end
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (drain_req && (expected_rsps.size() != 0 || req_valid)) begin
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs[0];
            send_gap <= quiet_send ? 0 : $urandom_range(0, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   int recv_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               if (rsp_data.status !== expected_rsps[0].status
                   || rsp_data.found !== expected_rsps[0].found
                   || rsp_data.position !== expected_rsps[0].position
                   || rsp_data.read_data !== expected_rsps[0].read_data
                   || rsp_data.count !== expected_rsps[0].count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("response mismatch: expected %p, got %p",
                              expected_rsps[0], rsp_data);
               end
               void'(expected_rsps.pop_front());
            end
            recv_gap = quiet_send ? 0 : $urandom_range(0, 13);
         end
         if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [3:0] c;
      for (int i = 0; i < CAPACITY; i++) shadow_list[i] = '0;
      shadow_len = 0;
      plan_len = 0;
      foreach (cmd_hits[i]) cmd_hits[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list cases, extremes, fill to full, every command
      plan_request(CMD_REVERSE, '0, '0);
      plan_request(CMD_SORT_UP, '0, '0);
      plan_request(CMD_READ, '0, 7'd0);
      plan_request(CMD_REMOVE_VAL, 32'sd5, '0);
      plan_request(CMD_FIND, 32'sd5, '0);
      plan_request(CMD_INSERT, 32'sh7fff_ffff, 7'd1);
      plan_request(CMD_INSERT, 32'sh8000_0000, 7'd0);
      plan_request(CMD_INSERT, 32'sh7fff_ffff, 7'd1);
      plan_request(CMD_APPEND, -32'sd1, '0);
      plan_request(CMD_FIND, -32'sd1, '0);
      plan_request(CMD_SORT_DOWN, '0, '0);
      plan_request(CMD_READ, '0, 7'd2);
      plan_request(CMD_WRITE, 32'sh5a5a_a5a5, 7'd1);
      plan_request(CMD_WRITE, '0, 7'h7f);
      plan_request(CMD_REMOVE_AT, '0, 7'd3);
      plan_request(CMD_REMOVE_AT, '0, 7'd0);
      plan_request(CMD_REMOVE_VAL, 32'sh5a5a_a5a5, '0);
      plan_request(4'd11, '1, 7'h7f);
      plan_request(4'd15, '0, '0);
      plan_request(CMD_CLEAR, '0, '0);
      for (int i = 0; i < CAPACITY; i++) plan_request(CMD_APPEND, random_value(), '0);
      plan_request(CMD_APPEND, 32'sd1, '0);
      plan_request(CMD_INSERT, 32'sd1, 7'd3);
      plan_request(CMD_INSERT, 32'sd1, 7'd65);
      plan_request(CMD_SORT_UP, '0, '0);
      plan_request(CMD_READ, '0, 7'd63);
      plan_request(CMD_REVERSE, '0, '0);
      plan_request(CMD_CLEAR, '0, '0);

      // random: small lists mostly, occasional refill toward full
      for (int n = 0; n < 1050; n++) begin
         if (n == 600) begin
            wait (pending_reqs.size() == 0);
            drain_req = 1'b1;
            wait (expected_rsps.size() == 0 && !req_valid);
            drain_req = 1'b0;
            quiet_send = 1'b1;
         end
         if (n == 700) quiet_send = 1'b0;
         if (n % 300 == 150)
            while (plan_len < CAPACITY) plan_request(CMD_APPEND, random_value(), '0);
         case ($urandom_range(0, 19))
            0, 1, 2:  c = CMD_APPEND;
            3, 4, 5:  c = CMD_INSERT;
            6:        c = CMD_REMOVE_VAL;
            7, 8:     c = CMD_REMOVE_AT;
            9:        c = CMD_FIND;
            10:       c = CMD_REVERSE;
            11:       c = CMD_SORT_UP;
            12:       c = CMD_SORT_DOWN;
            13, 14:   c = CMD_READ;
            15, 16:   c = CMD_WRITE;
            17:       c = (plan_len > 20) ? CMD_CLEAR : CMD_APPEND;
            18:       c = 4'($urandom_range(11, 15));
            default:  c = (plan_len > 40) ? CMD_REMOVE_AT : CMD_APPEND;
         endcase
         plan_request(c, random_value(), random_index());
         if (pending_reqs.size() > 16) wait (pending_reqs.size() <= 4);
      end
      wait (pending_reqs.size() == 0);
      stim_done = 1'b1;
      wait (expected_rsps.size() == 0);
      repeat (10000) @(posedge clock);
      $display("ran %0d requests, %0d responses; sort up %0d, sort down %0d, inserts %0d",
               req_count, rsp_count, cmd_hits[CMD_SORT_UP], cmd_hits[CMD_SORT_DOWN],
               cmd_hits[CMD_INSERT]);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count,
                  expected_rsps.size());
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("timeout");
      $display("Verification failed");
      $finish;
   end
endmodule
